// ----- rtl/adpcm_block_sample_decoder_defines.svh -----
// Assertion macros for the ADPCM block sample decoder.
`ifndef ADPCM_BLOCK_SAMPLE_DECODER_DEFINES_SVH
`define ADPCM_BLOCK_SAMPLE_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ABSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define ABSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/absd_pkg.sv -----
// Shared types, constants and coefficient lookup for the ADPCM decoder.
package absd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 8;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int SUM_W    = SAMPLE_W + 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [3:0] POS_HEADER = 4'd0;
  localparam logic [3:0] POS_FLAGS  = 4'd1;
  localparam logic [3:0] POS_LAST   = 4'd15;

  localparam logic signed [COEF_W-1:0] COEF_A1 = 8'sd60;
  localparam logic signed [COEF_W-1:0] COEF_A2 = 8'sd115;
  localparam logic signed [COEF_W-1:0] COEF_B2 = -8'sd52;
  localparam logic signed [COEF_W-1:0] COEF_A3 = 8'sd98;
  localparam logic signed [COEF_W-1:0] COEF_B3 = -8'sd55;
  localparam logic signed [COEF_W-1:0] COEF_A4 = 8'sd122;
  localparam logic signed [COEF_W-1:0] COEF_B4 = -8'sd60;

  typedef enum logic [1:0] {
    CMD_HEADER,
    CMD_FLAGS,
    CMD_DATA
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       clear;
    logic       last;
  } cmd_t;

  // Recent-sample coefficient; unlisted filters predict nothing.
  function automatic logic signed [COEF_W-1:0] coef_a(input logic [3:0] filt);
    logic signed [COEF_W-1:0] c;
    case (filt)
      4'd1:    c = COEF_A1;
      4'd2:    c = COEF_A2;
      4'd3:    c = COEF_A3;
      4'd4:    c = COEF_A4;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Older-sample coefficient.
  function automatic logic signed [COEF_W-1:0] coef_b(input logic [3:0] filt);
    logic signed [COEF_W-1:0] c;
    case (filt)
      4'd2:    c = COEF_B2;
      4'd3:    c = COEF_B3;
      4'd4:    c = COEF_B4;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/absd_if.sv -----
// Handshake channels: compressed byte input and decoded sample output.
interface absd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic [3:0] byte_position;
  logic       clear_history;

  modport source (output valid, byte_value, byte_position, clear_history, input ready);
  modport sink   (input valid, byte_value, byte_position, clear_history, output ready);
endinterface

interface absd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_first;
  logic [15:0] sample_second;
  logic        samples_valid;
  logic        loop_start_mark;
  logic        block_end_mark;
  logic        loop_repeat_mark;
  logic        last_of_block;

  modport source (output valid, sample_first, sample_second, samples_valid,
                  loop_start_mark, block_end_mark, loop_repeat_mark, last_of_block,
                  input ready);
  modport sink   (input valid, sample_first, sample_second, samples_valid,
                  loop_start_mark, block_end_mark, loop_repeat_mark, last_of_block,
                  output ready);
endinterface

// ----- rtl/absd_front.sv -----
// Front end: accept byte beats and classify them into commands.
module absd_front (
  absd_in_if.sink       compressed,
  input  logic          queue_full,
  output logic          push,
  output absd_pkg::cmd_t push_cmd
);

  assign compressed.ready = !queue_full;
  assign push = compressed.valid && !queue_full;

  always_comb begin
    push_cmd.data  = compressed.byte_value;
    push_cmd.clear = compressed.clear_history;
    push_cmd.last  = (compressed.byte_position == absd_pkg::POS_LAST);
    if (compressed.byte_position == absd_pkg::POS_HEADER) begin
      push_cmd.kind = absd_pkg::CMD_HEADER;
    end else if (compressed.byte_position == absd_pkg::POS_FLAGS) begin
      push_cmd.kind = absd_pkg::CMD_FLAGS;
    end else begin
      push_cmd.kind = absd_pkg::CMD_DATA;
    end
  end

endmodule

// ----- rtl/absd_cmd_fifo.sv -----
// Two-entry command queue between front end and decode engine.
module absd_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  absd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output absd_pkg::cmd_t head,
  output logic           empty
);

  localparam int PTR_W = $clog2(absd_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(absd_pkg::QUEUE_DEPTH + 1);

  absd_pkg::cmd_t entries [absd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(absd_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/absd_back.sv -----
// Decode engine: header state, flags results and two-nibble sample decode.
module absd_back (
  input  logic           clk,
  input  logic           rst,
  input  absd_pkg::cmd_t head,
  input  logic           empty,
  output logic           pop,
  output logic           mid_byte,
  absd_out_if.source     decoded
);

  logic signed [absd_pkg::SAMPLE_W-1:0] hist_recent;
  logic signed [absd_pkg::SAMPLE_W-1:0] hist_older;
  logic [3:0] filter_number;
  logic [3:0] shift_amount;
  logic       phase;
  logic signed [absd_pkg::SAMPLE_W-1:0] first_hold;

  logic [3:0] nib;
  logic signed [absd_pkg::SAMPLE_W-1:0] word;
  logic signed [absd_pkg::SAMPLE_W-1:0] scaled;
  logic signed [absd_pkg::PROD_W-1:0]   prod_a;
  logic signed [absd_pkg::PROD_W-1:0]   prod_b;
  logic signed [absd_pkg::SUM_W-1:0]    sum;
  logic signed [absd_pkg::SAMPLE_W-1:0] sample;
  logic out_free;
  logic do_header;
  logic do_flags;
  logic do_first;
  logic do_second;

  // One nibble per cycle while not stalled: scale, predict, saturate.
  always_comb begin
    nib    = phase ? head.data[7:4] : head.data[3:0];
    word   = {nib, 12'b0};
    scaled = word >>> shift_amount;
    prod_a = hist_recent * absd_pkg::coef_a(filter_number);
    prod_b = hist_older * absd_pkg::coef_b(filter_number);
    sum = $signed({{3{scaled[absd_pkg::SAMPLE_W-1]}}, scaled})
        + $signed({prod_a[absd_pkg::PROD_W-1], prod_a[absd_pkg::PROD_W-1:6]})
        + $signed({prod_b[absd_pkg::PROD_W-1], prod_b[absd_pkg::PROD_W-1:6]});
    if (sum > $signed(absd_pkg::SUM_W'(32767))) begin
      sample = 16'sh7fff;
    end else if (sum < -$signed(absd_pkg::SUM_W'(32768))) begin
      sample = 16'sh8000;
    end else begin
      sample = sum[absd_pkg::SAMPLE_W-1:0];
    end
  end

  always_comb begin
    out_free  = !decoded.valid || decoded.ready;
    do_header = !empty && (head.kind == absd_pkg::CMD_HEADER);
    do_flags  = !empty && (head.kind == absd_pkg::CMD_FLAGS) && out_free;
    do_first  = !empty && (head.kind == absd_pkg::CMD_DATA) && !phase;
    do_second = !empty && (head.kind == absd_pkg::CMD_DATA) && phase && out_free;
    pop       = do_header || do_flags || do_second;
  end

  assign mid_byte = phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_recent   <= '0;
      hist_older    <= '0;
      filter_number <= '0;
      shift_amount  <= '0;
      phase         <= 1'b0;
      decoded.valid <= 1'b0;
    end else begin
      if (do_header) begin
        filter_number <= head.data[7:4];
        shift_amount  <= head.data[3:0];
        if (head.clear) begin
          hist_recent <= '0;
          hist_older  <= '0;
        end
      end
      if (do_first || do_second) begin
        hist_older  <= hist_recent;
        hist_recent <= sample;
      end
      if (do_first) begin
        phase <= 1'b1;
      end else if (do_second) begin
        phase <= 1'b0;
      end
      if (do_flags || do_second) begin
        decoded.valid <= 1'b1;
      end else if (decoded.ready) begin
        decoded.valid <= 1'b0;
      end
    end
  end

  // Payload registers: hold the low-nibble sample, load results.
  always_ff @(posedge clk) begin
    if (do_first) begin
      first_hold <= sample;
    end
    if (do_flags) begin
      decoded.sample_first     <= '0;
      decoded.sample_second    <= '0;
      decoded.samples_valid    <= 1'b0;
      decoded.loop_start_mark  <= head.data[2];
      decoded.block_end_mark   <= head.data[0];
      decoded.loop_repeat_mark <= head.data[1];
      decoded.last_of_block    <= 1'b0;
    end else if (do_second) begin
      decoded.sample_first     <= first_hold;
      decoded.sample_second    <= sample;
      decoded.samples_valid    <= 1'b1;
      decoded.loop_start_mark  <= 1'b0;
      decoded.block_end_mark   <= 1'b0;
      decoded.loop_repeat_mark <= 1'b0;
      decoded.last_of_block    <= head.last;
    end
  end

endmodule

// ----- rtl/adpcm_block_sample_decoder.sv -----
// Top level of the single-voice ADPCM block sample decoder.
// Usage:
//   compressed carries one byte of a 16-byte ADPCM block per beat, with its
//   offset in the block and a clear_history flag that matters only on the
//   header byte (offset 0). decoded carries one result beat per flags byte
//   (offset 1, marks only) or data byte (offsets 2-15, two samples, low
//   nibble first). A header byte gives no result; it loads filter and shift.
// Flow:
//   A beat enters a two-entry command queue; the decode engine drains it.
//   A header or flags command is retired as a whole; a data byte stays at
//   the queue head and is decoded one nibble at a time through the single
//   multiply-add-saturate path, since the second nibble predicts from the
//   first. A result passes through the queue entry and the result register;
//   the queue takes new beats while the engine decodes a data byte.
// Stalls and reset:
//   When decoded is stalled, the result register holds, the engine stops
//   before loading a new result, and the queue fills; compressed.ready then
//   drops. rst (synchronous) empties the queue, drops the output beat and
//   zeroes history, filter and shift.
`include "adpcm_block_sample_decoder_defines.svh"

module adpcm_block_sample_decoder (
  input logic        clk,
  input logic        rst,
  absd_in_if.sink    compressed,
  absd_out_if.source decoded
);

  logic           q_push;
  absd_pkg::cmd_t q_push_cmd;
  logic           q_full;
  logic           q_pop;
  absd_pkg::cmd_t q_head;
  logic           q_empty;
  logic           mid_byte;

  // Classify beats into commands.
  absd_front u_front (
    .compressed (compressed),
    .queue_full (q_full),
    .push       (q_push),
    .push_cmd   (q_push_cmd)
  );

  // Decouple intake from decode.
  absd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // Advance history and produce results.
  absd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .empty    (q_empty),
    .pop      (q_pop),
    .mid_byte (mid_byte),
    .decoded  (decoded)
  );

  // A data byte stays at the queue head between its two nibbles.
  `ABSD_ASSERT_NOW(a_mid_byte_held, mid_byte, !q_empty && q_head.kind == absd_pkg::CMD_DATA, "data command lost mid-byte")
  // A new result beat comes only from a retired command.
  `ABSD_ASSERT_NOW(a_result_from_pop, $rose(decoded.valid), $past(q_pop), "result without retired command")
  // Sample beats carry no marks.
  `ABSD_ASSERT_NOW(a_data_no_marks, decoded.valid && decoded.samples_valid, !decoded.loop_start_mark && !decoded.block_end_mark && !decoded.loop_repeat_mark, "marks on sample beat")
  // Flags beats carry zero samples and no last-of-block flag.
  `ABSD_ASSERT_NOW(a_flags_clean, decoded.valid && !decoded.samples_valid, decoded.sample_first == '0 && decoded.sample_second == '0 && !decoded.last_of_block, "samples on flags beat")
  // The first nibble always leads into the second.
  `ABSD_ASSERT_NEXT(a_second_follows, !mid_byte && !q_empty && q_head.kind == absd_pkg::CMD_DATA, mid_byte, "second nibble not started")

endmodule
